>>> rtl/tfp_pkg.sv
// Shared types, constants and codes of the telemetry frame parser.
`timescale 1ns / 1ps

package tfp_pkg;

    // Frame layout
    localparam int unsigned NONCE_LEN    = 12;
    localparam int unsigned TAG_LEN      = 16;
    localparam int unsigned MAGIC_LEN    = 4;
    localparam int unsigned SESSION_END  = 12;
    localparam int unsigned SEQUENCE_END = 16;
    localparam int unsigned PREFIX_LEN   = 20;
    localparam int unsigned HEADER_LEN   = PREFIX_LEN + NONCE_LEN + TAG_LEN;

    localparam int unsigned COUNT_W = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0] MAGIC_BYTES [MAGIC_LEN] = '{8'h4E, 8'h33, 8'h57, 8'h32};

    // Result kinds
    localparam logic [1:0] KIND_NONCE   = 2'd0;
    localparam logic [1:0] KIND_TAG     = 2'd1;
    localparam logic [1:0] KIND_CIPHER  = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // Summary status
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED  = 2'd2;

    // Configuration registers
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        CFG_IDX_PAYLOAD_LIMIT = 1'b0;
    localparam logic        CFG_IDX_MAX_CIPHER    = 1'b1;
    localparam logic [COUNT_W-1:0] PAYLOAD_LIMIT_RESET = 12'd1470;
    localparam logic [COUNT_W-1:0] MAX_CIPHER_RESET    = 12'd1422;

    // Result queue
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         byte_value;
        logic [COUNT_W-1:0] byte_index;
        logic [63:0]        session_id;
        logic [31:0]        sequence_res;
        logic [31:0]        epoch;
        logic [1:0]         status;
        logic               last;
    } out_t;

    typedef struct packed {
        logic [COUNT_W-1:0] payload_limit;
        logic [COUNT_W-1:0] max_cipher_len;
    } cfg_t;

    // Up to two results from one accepted byte: byte result first, then summary
    typedef struct packed {
        logic byte_valid;
        out_t byte_res;
        logic sum_valid;
        out_t sum_res;
    } push_t;

endpackage

>>> rtl/telemetry_frame_parser_core.sv
// Top level of the telemetry frame parser.
//
//  channel   direction  handshake                  payload
//  byte      in         byte_valid / byte_stall    byte_data   (in_t)
//  result    out        result_valid / result_stall result_data (out_t)
//  config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One byte is taken per cycle unless byte_stall; its results land in the result queue
// at the same edge. A byte yields zero, one or two results; the single result port
// drains one a cycle unless result_stall; a passed-on last byte pushes two at once.
// byte_stall rises when the queue has fewer than two free entries.
// Reset clears the frame state and the queue and restores the register defaults.
`timescale 1ns / 1ps

module telemetry_frame_parser_core
    import tfp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  in_t                   byte_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_t                  result_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t  cfg;
    push_t push;
    logic  queue_full;
    logic  accept;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !byte_stall;

    tfp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tfp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_data),
        .cfg    (cfg),
        .push   (push)
    );

    tfp_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (queue_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result_data)
    );

endmodule

>>> rtl/tfp_cfg.sv
// APB configuration registers of the telemetry frame parser.
`timescale 1ns / 1ps

module tfp_cfg
    import tfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [COUNT_W-1:0] payload_limit_reg;
    logic [COUNT_W-1:0] max_cipher_reg;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_limit_reg <= PAYLOAD_LIMIT_RESET;
            max_cipher_reg    <= MAX_CIPHER_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                CFG_IDX_PAYLOAD_LIMIT: payload_limit_reg <= pwdata[COUNT_W-1:0];
                CFG_IDX_MAX_CIPHER:    max_cipher_reg    <= pwdata[COUNT_W-1:0];
                default:               payload_limit_reg <= payload_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            CFG_IDX_PAYLOAD_LIMIT: prdata = {{(32-COUNT_W){1'b0}}, payload_limit_reg};
            CFG_IDX_MAX_CIPHER:    prdata = {{(32-COUNT_W){1'b0}}, max_cipher_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.payload_limit  = payload_limit_reg;
    assign cfg.max_cipher_len = max_cipher_reg;

endmodule

>>> rtl/tfp_parser.sv
// Per-byte frame state and result generation.
`timescale 1ns / 1ps

module tfp_parser
    import tfp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  in_t   item,
    input  cfg_t  cfg,
    output push_t push
);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               magic_match_reg, magic_match_next;
    logic [63:0]        session_reg, session_next;
    logic [31:0]        sequence_reg, sequence_next;
    logic [31:0]        epoch_reg, epoch_next;

    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] offset;
    logic [COUNT_W:0]   frame_len;
    logic [COUNT_W:0]   cipher_len;
    logic               pass_on;
    logic [1:0]         byte_kind;
    logic [1:0]         status;

    assign pos    = byte_count_reg;
    assign offset = pos - COUNT_W'(PREFIX_LEN);

    always_comb
    begin
        magic_match_next = magic_match_reg;
        session_next     = session_reg;
        sequence_next    = sequence_reg;
        epoch_next       = epoch_reg;
        pass_on          = 1'b0;

        if (pos < COUNT_W'(MAGIC_LEN))
        begin
            if (item.data_byte != MAGIC_BYTES[pos[1:0]])
                magic_match_next = 1'b0;
        end
        else if (pos < COUNT_W'(SESSION_END))
            session_next = {session_reg[55:0], item.data_byte};
        else if (pos < COUNT_W'(SEQUENCE_END))
            sequence_next = {sequence_reg[23:0], item.data_byte};
        else if (pos < COUNT_W'(PREFIX_LEN))
            epoch_next = {epoch_reg[23:0], item.data_byte};
        else
            pass_on = magic_match_reg && (pos < cfg.payload_limit);

        if (offset < COUNT_W'(NONCE_LEN))
            byte_kind = KIND_NONCE;
        else if (offset < COUNT_W'(NONCE_LEN + TAG_LEN))
            byte_kind = KIND_TAG;
        else
            byte_kind = KIND_CIPHER;

        // saturated count stands for "at least 4096", still over any limit
        frame_len  = {1'b0, pos} + 1'b1;
        cipher_len = frame_len - (COUNT_W+1)'(HEADER_LEN);
        if (frame_len <= (COUNT_W+1)'(HEADER_LEN))
            status = STATUS_TRUNCATED;
        else if (frame_len > {1'b0, cfg.payload_limit} || !magic_match_next ||
                 session_next == '0 || epoch_next == '0 ||
                 cipher_len > {1'b0, cfg.max_cipher_len})
            status = STATUS_REJECTED;
        else
            status = STATUS_OK;

        byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 1'b1;
    end

    always_comb
    begin
        push.byte_valid              = accept && pass_on;
        push.byte_res                = '0;
        push.byte_res.kind           = byte_kind;
        push.byte_res.byte_value     = item.data_byte;
        push.byte_res.byte_index     = offset;
        push.byte_res.last           = !item.end_of_frame;

        push.sum_valid               = accept && item.end_of_frame;
        push.sum_res                 = '0;
        push.sum_res.kind            = KIND_SUMMARY;
        push.sum_res.session_id      = session_next;
        push.sum_res.sequence_res    = sequence_next;
        push.sum_res.epoch           = epoch_next;
        push.sum_res.status          = status;
        push.sum_res.last            = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            magic_match_reg <= 1'b1;
            session_reg     <= '0;
            sequence_reg    <= '0;
            epoch_reg       <= '0;
        end
        else if (accept)
        begin
            if (item.end_of_frame)
            begin
                byte_count_reg  <= '0;
                magic_match_reg <= 1'b1;
                session_reg     <= '0;
                sequence_reg    <= '0;
                epoch_reg       <= '0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                magic_match_reg <= magic_match_next;
                session_reg     <= session_next;
                sequence_reg    <= sequence_next;
                epoch_reg       <= epoch_next;
            end
        end
    end

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_of_frame |=> byte_count_reg == '0 && magic_match_reg)
        else $error("frame state not cleared after end of frame");

    a_no_pass_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        push.byte_valid |-> byte_count_reg >= COUNT_W'(PREFIX_LEN) && magic_match_reg)
        else $error("byte passed on from the fixed prefix or after bad magic");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !item.end_of_frame && byte_count_reg == COUNT_MAX
        |=> byte_count_reg == COUNT_MAX)
        else $error("byte count wrapped instead of saturating");

endmodule

>>> rtl/tfp_out_queue.sv
// Result queue taking up to two results a cycle, one out unless stalled.
`timescale 1ns / 1ps

module tfp_out_queue
    import tfp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  full,
    output logic  out_valid,
    input  logic  out_stall,
    output out_t  out_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    out_t             entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_2nd;
    logic [1:0]       n_push;
    logic             pop;
    out_t             first_res;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign n_push     = {1'b0, push.byte_valid} + {1'b0, push.sum_valid};
    assign pop        = out_valid && !out_stall;
    assign wr_ptr_2nd = ptr_inc(wr_ptr_reg);
    assign first_res  = push.byte_valid ? push.byte_res : push.sum_res;

    // room for two results is needed before a byte can be taken
    assign full      = count_reg > CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_mem[rd_ptr_reg];

    always_comb
    begin
        case (n_push)
            2'd1:    wr_ptr_next = wr_ptr_2nd;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_2nd);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            entry_mem[wr_ptr_reg] <= first_res;
        if (n_push == 2'd2)
            entry_mem[wr_ptr_2nd] <= push.sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + CNT_W'($past(n_push)) - CNT_W'($past(pop)))
        else $error("result queue count lost track");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        n_push != 2'd0 |-> CNT_W'(DEPTH) - count_reg >= CNT_W'(n_push))
        else $error("push into result queue without room");

endmodule

>>> test/testbench.sv
// Testbench for the telemetry frame parser core: directed table and random frames.
`timescale 1ns / 1ps

module testbench;
    import tfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BYTES  = 420;
    localparam int unsigned PHASES        = 7;
    localparam int unsigned RANDOM_PHASE  = 5;
    localparam int unsigned PLAN_ROWS     = 21;

    localparam logic [CFG_ADDR_W-1:0] ADDR_PAYLOAD_LIMIT = {CFG_IDX_PAYLOAD_LIMIT, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_CIPHER    = {CFG_IDX_MAX_CIPHER, 2'b00};

    // Register settings per phase, random in RANDOM_PHASE; phase 0 runs on reset values
    localparam logic [COUNT_W-1:0] PHASE_LIMIT [PHASES] =
        '{PAYLOAD_LIMIT_RESET, 12'd49, 12'd4095, 12'd60, 12'd25, 12'd0, PAYLOAD_LIMIT_RESET};
    localparam logic [COUNT_W-1:0] PHASE_CIPHER [PHASES] =
        '{MAX_CIPHER_RESET, 12'd0, 12'd4095, 12'd8, 12'd1, 12'd0, MAX_CIPHER_RESET};

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_frame;
        logic        typed;        // summary written out in the row
        logic [63:0] session_id;
        logic [31:0] sequence_res;
        logic [31:0] epoch;
        logic [1:0]  status;
    } plan_row_t;

    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 64'h0, 32'h0, 32'h0, STATUS_TRUNCATED},
        '{8'hFF, 1'b1, 1'b1, 64'h0, 32'h0, 32'h0, STATUS_TRUNCATED},
        '{8'h4E, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'h33, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'h57, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'h32, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'h80, 1'b1, 1'b1, 64'h80, 32'h0, 32'h0, STATUS_TRUNCATED},
        '{8'h4E, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'h33, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'h57, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'h32, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'hFF, 1'b0, 1'b0, 64'h0, 32'h0, 32'h0, STATUS_OK},
        '{8'h01, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1, 32'h0, STATUS_TRUNCATED},
        '{8'h4F, 1'b1, 1'b1, 64'h0, 32'h0, 32'h0, STATUS_TRUNCATED}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  byte_valid;
    logic                  byte_stall;
    in_t                   byte_data;
    logic                  result_valid;
    logic                  result_stall;
    out_t                  result_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Parser state as predicted
    logic [COUNT_W-1:0] frame_count = '0;
    logic               magic_ok = 1'b1;
    logic [63:0]        session_acc = '0;
    logic [31:0]        sequence_acc = '0;
    logic [31:0]        epoch_acc = '0;
    logic [COUNT_W-1:0] limit_cfg = PAYLOAD_LIMIT_RESET;
    logic [COUNT_W-1:0] cipher_cfg = MAX_CIPHER_RESET;

    out_t        pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned frames_seen = 0;
    int unsigned status_tally [3] = '{0, 0, 0};
    int unsigned cycle_count = 0;
    bit          calm;

    telemetry_frame_parser_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
        $display("testbench: errors");
        $finish;
    end

    // Alternates busy stretches with quiet ones where neither side idles
    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(150, 600)) @(posedge clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void frame_clear();
        frame_count  = '0;
        magic_ok     = 1'b1;
        session_acc  = '0;
        sequence_acc = '0;
        epoch_acc    = '0;
    endfunction

    // Advances the predicted parser by one byte; queues its results when keep is set
    function automatic void parse_byte(in_t item, bit keep);
        int unsigned pos;
        int unsigned off;
        int unsigned flen;
        out_t        res;
        pos = frame_count;
        if (pos < MAGIC_LEN)
        begin
            if (item.data_byte != MAGIC_BYTES[pos])
                magic_ok = 1'b0;
        end
        else if (pos < SESSION_END)
            session_acc = {session_acc[55:0], item.data_byte};
        else if (pos < SEQUENCE_END)
            sequence_acc = {sequence_acc[23:0], item.data_byte};
        else if (pos < PREFIX_LEN)
            epoch_acc = {epoch_acc[23:0], item.data_byte};
        else if (magic_ok && pos < limit_cfg)
        begin
            off = pos - PREFIX_LEN;
            res = '0;
            if (off < NONCE_LEN)
                res.kind = KIND_NONCE;
            else if (off < NONCE_LEN + TAG_LEN)
                res.kind = KIND_TAG;
            else
                res.kind = KIND_CIPHER;
            res.byte_value = item.data_byte;
            res.byte_index = off[COUNT_W-1:0];
            res.last       = ~item.end_of_frame;
            if (keep)
                pending_results = {pending_results, res};
        end

        if (frame_count != COUNT_MAX)
            frame_count = frame_count + 1'b1;

        if (item.end_of_frame)
        begin
            // a saturated count stands for a frame of 4096 bytes or more
            flen = pos + 1;
            res = '0;
            res.kind         = KIND_SUMMARY;
            res.session_id   = session_acc;
            res.sequence_res = sequence_acc;
            res.epoch        = epoch_acc;
            res.last         = 1'b1;
            if (flen <= HEADER_LEN)
                res.status = STATUS_TRUNCATED;
            else if (flen > limit_cfg || !magic_ok || session_acc == '0 || epoch_acc == '0
                     || flen - HEADER_LEN > cipher_cfg)
                res.status = STATUS_REJECTED;
            else
                res.status = STATUS_OK;
            status_tally[res.status]++;
            frames_seen++;
            if (keep)
                pending_results = {pending_results, res};
            frame_clear();
        end
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, result_data);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("kind", want.kind, result_data.kind);
                compare_field("byte_value", want.byte_value, result_data.byte_value);
                compare_field("byte_index", want.byte_index, result_data.byte_index);
                compare_field("session_id", want.session_id, result_data.session_id);
                compare_field("sequence_res", want.sequence_res, result_data.sequence_res);
                compare_field("epoch", want.epoch, result_data.epoch);
                compare_field("status", want.status, result_data.status);
                compare_field("last", want.last, result_data.last);
            end
        end
    end

    // Result side back-pressure
    initial
    begin
        int unsigned hold;
        hold = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                hold--;
            end
            else
            begin
                result_stall <= 1'b0;
                if ($urandom_range(0, 2) == 0)
                    hold = pick_gap();
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(in_t item, bit typed, out_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= item;
        do
            @(posedge clk);
        while (byte_stall);
        parse_byte(item, !typed);
        if (typed)
            pending_results = {pending_results, want};
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        byte_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(logic [CFG_ADDR_W-1:0] addr, logic [COUNT_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_PAYLOAD_LIMIT)
            limit_cfg = value;
        else
            cipher_cfg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(logic [CFG_ADDR_W-1:0] addr, logic [COUNT_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[COUNT_W-1:0] !== want)
        begin
            $display("%0t: register %0h read mismatch, expected %0h, got %0h",
                     $time, addr, want, prdata[COUNT_W-1:0]);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Header laid out big-endian; pause_at holds the sender until the output is empty
    task automatic send_frame(int len, logic [63:0] sess, logic [31:0] seq, logic [31:0] ep,
                              bit magic_good, bit noise, int pause_at);
        in_t         item;
        int unsigned bad_pos;
        logic [7:0]  flip;
        bad_pos = $urandom_range(0, MAGIC_LEN - 1);
        flip    = 8'h01 << $urandom_range(0, 7);
        for (int i = 0; i < len; i++)
        begin
            item.data_byte = 8'($urandom);
            if (!noise)
            begin
                if (i < MAGIC_LEN)
                    item.data_byte = MAGIC_BYTES[i]
                                     ^ ((!magic_good && i == bad_pos) ? flip : 8'h00);
                else if (i < SESSION_END)
                    item.data_byte = sess[8 * (SESSION_END - 1 - i) +: 8];
                else if (i < SEQUENCE_END)
                    item.data_byte = seq[8 * (SEQUENCE_END - 1 - i) +: 8];
                else if (i < PREFIX_LEN)
                    item.data_byte = ep[8 * (PREFIX_LEN - 1 - i) +: 8];
            end
            item.end_of_frame = (i == len - 1);
            if (i == pause_at)
                drain_results();
            send_byte(item, 1'b0, '0);
        end
    endtask

    task automatic random_frame();
        int unsigned r;
        int          len;
        logic [63:0] sess;
        logic [31:0] ep;
        r = $urandom_range(0, 99);
        if (r < 15)
            len = $urandom_range(1, HEADER_LEN);
        else if (r < 30 && limit_cfg <= 400)
            len = int'(limit_cfg) + int'($urandom_range(0, 2)) - 1;
        else if (r < 45 && cipher_cfg <= 300)
            len = HEADER_LEN + int'(cipher_cfg) + int'($urandom_range(0, 2)) - 1;
        else
            len = HEADER_LEN + $urandom_range(1, 30);
        if (len < 1)
            len = 1;
        sess = {$urandom, $urandom};
        if ($urandom_range(0, 14) == 0)
            sess = '0;
        ep = $urandom;
        if ($urandom_range(0, 14) == 0)
            ep = '0;
        send_frame(len, sess, $urandom, ep, $urandom_range(0, 9) != 0,
                   $urandom_range(0, 11) == 0,
                   ($urandom_range(0, 24) == 0) ? int'($urandom_range(0, len - 1)) : -1);
    endtask

    initial
    begin
        plan_row_t          row;
        in_t                item;
        out_t               want;
        int unsigned        phase_end;
        logic [COUNT_W-1:0] new_limit;
        logic [COUNT_W-1:0] new_cipher;

        byte_valid = 1'b0;
        byte_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        rst_n      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        reg_read(ADDR_PAYLOAD_LIMIT, PAYLOAD_LIMIT_RESET);
        reg_read(ADDR_MAX_CIPHER, MAX_CIPHER_RESET);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            row = DIRECTED_PLAN[i];
            item.data_byte    = row.data_byte;
            item.end_of_frame = row.end_of_frame;
            want = '0;
            want.kind         = KIND_SUMMARY;
            want.session_id   = row.session_id;
            want.sequence_res = row.sequence_res;
            want.epoch        = row.epoch;
            want.status       = row.status;
            want.last         = 1'b1;
            send_byte(item, row.typed, want);
        end

        // Shortest good frame (paused mid-nonce), zero session, zero epoch, bad magic
        send_frame(HEADER_LEN + 1, 64'h1, 32'h0, 32'h1, 1'b1, 1'b0, 30);
        send_frame(HEADER_LEN + 4, 64'h0, 32'hFFFF_FFFF, 32'h5, 1'b1, 1'b0, -1);
        send_frame(HEADER_LEN + 4, 64'h8000_0000_0000_0000, 32'h7, 32'h0, 1'b1, 1'b0, -1);
        send_frame(HEADER_LEN + 12, 64'h3, 32'h9, 32'h2, 1'b0, 1'b0, -1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase != 0)
            begin
                new_limit  = PHASE_LIMIT[phase];
                new_cipher = PHASE_CIPHER[phase];
                if (phase == RANDOM_PHASE)
                begin
                    new_limit  = COUNT_W'($urandom_range(49, 400));
                    new_cipher = COUNT_W'($urandom_range(0, 60));
                end
                reg_write(ADDR_PAYLOAD_LIMIT, new_limit);
                reg_write(ADDR_MAX_CIPHER, new_cipher);
                reg_read(ADDR_PAYLOAD_LIMIT, new_limit);
                reg_read(ADDR_MAX_CIPHER, new_cipher);
            end
            phase_end = bytes_sent + RANDOM_BYTES / PHASES;
            while (bytes_sent < phase_end)
                random_frame();
        end

        settle();

        $display("run: %0d bytes in %0d frames, %0d results checked, %0d mismatches",
                 bytes_sent, frames_seen, results_seen, mismatch_count);
        $display("run: summaries ok %0d, truncated %0d, rejected %0d over %0d register phases",
                 status_tally[STATUS_OK], status_tally[STATUS_TRUNCATED],
                 status_tally[STATUS_REJECTED], PHASES);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
